// ===== design/best_worst_fit_free_list_allocator_macros.svh =====
// Assertion macros for the free list allocator
`ifndef BEST_WORST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH
`define BEST_WORST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH
// assert that a condition implies a consequence in the same cycle
`define BWF_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("lbl failed");
// assert that a condition implies a consequence in the next cycle
`define BWF_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("lbl failed");
`endif

// ===== design/bwf_pkg.sv =====
// Shared constants and types for the free list allocator
package bwf_pkg;
    localparam int TableEntries = 16;
    localparam int AddrWidth    = 16;
    localparam int AlignBytes   = 4;
    localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
    localparam int CntW = $clog2(TableEntries + 1);

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_ALLOC = 2'd1;
    localparam logic [1:0] MODE_FREE  = 2'd2;

    localparam logic [2:0] ST_ALLOC  = 3'd0;
    localparam logic [2:0] ST_NOFIT  = 3'd1;
    localparam logic [2:0] ST_MERGED = 3'd2;
    localparam logic [2:0] ST_NEW    = 3'd3;
    localparam logic [2:0] ST_FULL   = 3'd4;
    localparam logic [2:0] ST_LOADED = 3'd5;

    typedef logic [AddrWidth-1:0] t_addr;

    // token passed along the cell chain
    typedef struct packed {
        logic        alloc;
        logic        policy;
        logic [AddrWidth:0] rounded;
        t_addr       fstart;
        t_addr       fsize;
        t_addr       fend;
        logic        found;
        logic [IdxW-1:0] pick;
        t_addr       pick_len;
        t_addr       pick_start;
    } t_tok;
endpackage

// ===== design/bwf_cell.sv =====
// One table cell: holds an entry and updates the search token
module bwf_cell (
    input  logic                    i_clk,
    input  logic [bwf_pkg::IdxW-1:0] i_idx,
    input  logic                    i_valid,
    input  bwf_pkg::t_tok           i_tok,
    output bwf_pkg::t_tok           o_tok,
    input  logic                    i_wr,
    input  bwf_pkg::t_addr          i_wstart,
    input  bwf_pkg::t_addr          i_wlen
);
    bwf_pkg::t_addr r_start, r_len;
    bwf_pkg::t_addr w_end;
    logic w_fit, w_better, w_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_start <= i_wstart;
            r_len   <= i_wlen;
        end
    end

    assign w_end = r_start + r_len;

    always_comb begin
        o_tok = i_tok;
        w_fit = {1'b0, r_len} > i_tok.rounded;
        w_better = i_tok.policy ? (r_len > i_tok.pick_len) : (r_len < i_tok.pick_len);
        w_hit = (r_start == i_tok.fend) || (w_end == i_tok.fstart);
        if (i_valid && !i_tok.found && !i_tok.alloc && w_hit) begin
            o_tok.found = 1'b1;
            o_tok.pick = i_idx;
            o_tok.pick_len = r_len;
            o_tok.pick_start = r_start;
        end else if (i_valid && i_tok.alloc && w_fit && (!i_tok.found || w_better)) begin
            o_tok.found = 1'b1;
            o_tok.pick = i_idx;
            o_tok.pick_len = r_len;
            o_tok.pick_start = r_start;
        end
    end
endmodule

// ===== design/best_worst_fit_free_list_allocator.sv =====
// Top level of the best or worst fit free list allocator
// channel | direction | fields
// in      | input     | mode, region_start, region_size
// out     | output    | status, result_address, chosen_block_size
// cfg     | input     | fit_policy
// An allocate or free scans the whole table before the next transfer: a token
// walks the cell row one cell per cycle, then the update state writes the entry and loads
// the result. Load and unused mode skip the scan. One item is in work at a time.
// Reset empties the table and sets best fit. A stalled result holds; a finished item
// waits in the update state until the result register is free.
module best_worst_fit_free_list_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_region_start,
    input  logic [15:0] i_region_size,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [15:0] o_result_address,
    output logic [15:0] o_chosen_block_size
);
    `include "best_worst_fit_free_list_allocator_macros.svh"
    localparam int N = bwf_pkg::TableEntries;
    localparam int AW = bwf_pkg::AddrWidth;
    localparam logic [1:0] S_IDLE = 2'd0, S_SCAN = 2'd1, S_DONE = 2'd2;

    logic [1:0] r_state;
    logic r_policy;
    logic [bwf_pkg::CntW-1:0] r_count;
    logic [bwf_pkg::IdxW-1:0] r_pos;
    bwf_pkg::t_tok r_tok;
    logic [1:0] r_mode;
    logic r_ovalid;
    logic [2:0] r_status;
    bwf_pkg::t_addr r_addr, r_size;

    bwf_pkg::t_tok w_tok_out [N];
    logic [N-1:0] w_wr;
    bwf_pkg::t_addr w_wstart, w_wlen;
    logic [bwf_pkg::IdxW-1:0] w_widx;
    logic w_do_wr;
    logic [AW:0] w_sum;
    bwf_pkg::t_addr w_sat;
    logic w_accept;
    logic w_out_free;
    logic [AW:0] w_rnd;
    bwf_pkg::t_tok w_t0;
    bwf_pkg::t_tok w_next;
    logic [bwf_pkg::CntW-1:0] w_pos_ext;

    assign w_accept = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign w_out_free = !r_ovalid || !i_stall;
    assign w_pos_ext = bwf_pkg::CntW'(r_pos);

    always_comb begin
        w_rnd = ({1'b0, i_region_size} + (AW+1)'(bwf_pkg::AlignBytes - 1)) &
                ~((AW+1)'(bwf_pkg::AlignBytes - 1));
        w_t0 = '0;
        w_t0.alloc = (i_mode == bwf_pkg::MODE_ALLOC);
        w_t0.policy = r_policy;
        w_t0.rounded = w_rnd;
        w_t0.fstart = i_region_start;
        w_t0.fsize = i_region_size;
        w_t0.fend = i_region_start + i_region_size;
    end

    genvar g;
    for (g = 0; g < N; g++) begin : g_cell
        bwf_cell u_cell (
            .i_clk    (i_clk),
            .i_idx    (bwf_pkg::IdxW'(g)),
            .i_valid  ((r_pos == bwf_pkg::IdxW'(g)) && (w_pos_ext < r_count)),
            .i_tok    (r_tok),
            .o_tok    (w_tok_out[g]),
            .i_wr     (w_wr[g]),
            .i_wstart (w_wstart),
            .i_wlen   (w_wlen)
        );
        assign w_wr[g] = w_do_wr && (w_widx == bwf_pkg::IdxW'(g));
    end

    assign w_next = w_tok_out[r_pos];
    assign w_sum = {1'b0, r_tok.pick_len} + {1'b0, r_tok.fsize};
    assign w_sat = w_sum[AW] ? '1 : w_sum[AW-1:0];

    always_comb begin
        w_do_wr = 1'b0;
        w_widx = r_count[bwf_pkg::IdxW-1:0];
        w_wstart = r_tok.fstart;
        w_wlen = r_tok.fsize;
        if (r_state == S_DONE && w_out_free) begin
            if (r_mode == bwf_pkg::MODE_ALLOC) begin
                w_do_wr = r_tok.found;
                w_widx = r_tok.pick;
                w_wstart = r_tok.pick_start + r_tok.rounded[AW-1:0];
                w_wlen = r_tok.pick_len - r_tok.rounded[AW-1:0];
            end else if (r_mode == bwf_pkg::MODE_FREE && r_tok.found) begin
                w_do_wr = 1'b1;
                w_widx = r_tok.pick;
                w_wstart = (r_tok.pick_start == r_tok.fend) ? r_tok.fstart
                                                            : r_tok.pick_start;
                w_wlen = w_sat;
            end else if (r_mode == bwf_pkg::MODE_LOAD || r_mode == bwf_pkg::MODE_FREE) begin
                w_do_wr = (r_count < bwf_pkg::CntW'(N));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_policy <= 1'b0;
            r_count <= '0;
            r_ovalid <= 1'b0;
            r_pos <= '0;
        end else begin
            if (i_cfg_we) r_policy <= i_cfg_data;
            if (r_state == S_DONE && w_out_free) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_tok <= w_t0;
                        r_mode <= i_mode;
                        r_pos <= '0;
                        r_state <= (i_mode == bwf_pkg::MODE_ALLOC ||
                                    i_mode == bwf_pkg::MODE_FREE) ? S_SCAN : S_DONE;
                    end
                end
                S_SCAN: begin
                    r_tok <= w_next;
                    r_pos <= r_pos + 1'b1;
                    if (r_pos == bwf_pkg::IdxW'(N-1)) r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                        if (w_do_wr && !(r_mode == bwf_pkg::MODE_ALLOC) &&
                            !(r_mode == bwf_pkg::MODE_FREE && r_tok.found))
                            r_count <= r_count + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_status <= bwf_pkg::ST_NOFIT;
            r_addr <= '0;
            r_size <= '0;
            if (r_mode == bwf_pkg::MODE_ALLOC) begin
                if (r_tok.found) begin
                    r_status <= bwf_pkg::ST_ALLOC;
                    r_addr <= r_tok.pick_start;
                    r_size <= r_tok.pick_len;
                end
            end else if (r_mode == bwf_pkg::MODE_FREE && r_tok.found) begin
                r_status <= bwf_pkg::ST_MERGED;
                r_addr <= w_wstart;
                r_size <= w_sat;
            end else if (r_mode == bwf_pkg::MODE_LOAD || r_mode == bwf_pkg::MODE_FREE) begin
                r_addr <= r_tok.fstart;
                r_size <= r_tok.fsize;
                if (!w_do_wr) r_status <= bwf_pkg::ST_FULL;
                else if (r_mode == bwf_pkg::MODE_LOAD) r_status <= bwf_pkg::ST_LOADED;
                else r_status <= bwf_pkg::ST_NEW;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_status = r_status;
    assign o_result_address = r_addr;
    assign o_chosen_block_size = r_size;

    `BWF_ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= bwf_pkg::CntW'(N))
    `BWF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `BWF_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall, $stable({o_status, o_result_address, o_chosen_block_size}))
    `BWF_ASSERT_NEXT(a_done_out, i_clk, i_rst_n, r_state == S_DONE, r_ovalid)
endmodule

// ===== tb/sv/tb_best_worst_fit_free_list_allocator.sv =====
// Testbench for the best or worst fit free list allocator: model-based checking
`timescale 1ns / 1ps
module tb_best_worst_fit_free_list_allocator;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_data = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_mode = '0;
    logic [15:0] i_region_start = '0;
    logic [15:0] i_region_size = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    logic [15:0] o_result_address;
    logic [15:0] o_chosen_block_size;

    typedef struct packed {
        logic [2:0]     status;
        bwf_pkg::t_addr addr;
        bwf_pkg::t_addr size;
    } t_answer;

    bwf_pkg::t_addr tbl_start [bwf_pkg::TableEntries];
    bwf_pkg::t_addr tbl_len [bwf_pkg::TableEntries];
    int        tbl_count = 0;
    logic      policy = 1'b0;
    t_answer   pending_answers [$];
    int        error_count = 0;
    int        cycle_count = 0;

    best_worst_fit_free_list_allocator dut (.*);

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report(input string what);
        $display("ERROR @%0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic t_answer add_entry(bwf_pkg::t_addr s, bwf_pkg::t_addr n,
                                          logic [2:0] ok);
        if (tbl_count >= bwf_pkg::TableEntries) return '{bwf_pkg::ST_FULL, s, n};
        tbl_start[tbl_count] = s;
        tbl_len[tbl_count] = n;
        tbl_count++;
        return '{ok, s, n};
    endfunction

    function automatic bwf_pkg::t_addr sat_sum(bwf_pkg::t_addr a, bwf_pkg::t_addr b);
        logic [bwf_pkg::AddrWidth:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[bwf_pkg::AddrWidth] ? '1 : s[bwf_pkg::AddrWidth-1:0];
    endfunction

    function automatic t_answer predict_allocator(logic [1:0] m, bwf_pkg::t_addr s,
                                                  bwf_pkg::t_addr n);
        logic [bwf_pkg::AddrWidth:0] rnd;
        bit   found;
        int   pick;
        bwf_pkg::t_addr plen, fend, e, a;
        found = 0;
        pick = 0;
        plen = '0;
        case (m)
            bwf_pkg::MODE_LOAD: return add_entry(s, n, bwf_pkg::ST_LOADED);
            bwf_pkg::MODE_ALLOC: begin
                rnd = ({1'b0, n} + (bwf_pkg::AddrWidth+1)'(bwf_pkg::AlignBytes - 1)) &
                      ~((bwf_pkg::AddrWidth+1)'(bwf_pkg::AlignBytes - 1));
                for (int i = 0; i < tbl_count; i++) begin
                    if ({1'b0, tbl_len[i]} <= rnd) continue;
                    if (!found || (policy ? tbl_len[i] > plen : tbl_len[i] < plen)) begin
                        found = 1;
                        pick = i;
                        plen = tbl_len[i];
                    end
                end
                if (!found) return '{bwf_pkg::ST_NOFIT, '0, '0};
                a = tbl_start[pick];
                tbl_start[pick] = a + rnd[bwf_pkg::AddrWidth-1:0];
                tbl_len[pick] = plen - rnd[bwf_pkg::AddrWidth-1:0];
                return '{bwf_pkg::ST_ALLOC, a, plen};
            end
            bwf_pkg::MODE_FREE: begin
                fend = s + n;
                for (int i = 0; i < tbl_count; i++) begin
                    e = tbl_start[i] + tbl_len[i];
                    if (tbl_start[i] == fend) begin
                        tbl_start[i] = s;
                        tbl_len[i] = sat_sum(tbl_len[i], n);
                        return '{bwf_pkg::ST_MERGED, s, tbl_len[i]};
                    end
                    if (e == s) begin
                        tbl_len[i] = sat_sum(tbl_len[i], n);
                        return '{bwf_pkg::ST_MERGED, tbl_start[i], tbl_len[i]};
                    end
                end
                return add_entry(s, n, bwf_pkg::ST_NEW);
            end
            default: return '{bwf_pkg::ST_NOFIT, '0, '0};
        endcase
    endfunction

    // checker
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_answers.size() == 0) begin
                report("result with no expectation");
            end else begin
                want = pending_answers.pop_front();
                if (o_status !== want.status)
                    report($sformatf("status %0d want %0d", o_status, want.status));
                if (o_result_address !== want.addr)
                    report($sformatf("address %h want %h", o_result_address, want.addr));
                if (o_chosen_block_size !== want.size)
                    report($sformatf("size %h want %h", o_chosen_block_size, want.size));
            end
        end
    end

    // receiver stall: a random stall drawn anew per result, often none
    initial begin
        int w;
        forever begin
            @(negedge i_clk);
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            i_stall <= (w != 0);
            repeat (w) @(negedge i_clk);
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
        end
    end

    bit burst = 0;

    task automatic send_item(logic [1:0] m, bwf_pkg::t_addr s, bwf_pkg::t_addr n);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_mode <= m;
        i_region_start <= s;
        i_region_size <= n;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        pending_answers.push_back(predict_allocator(m, s, n));
        @(negedge i_clk);
    endtask

    task automatic drain_and_set_policy(logic p);
        i_valid <= 1'b0;
        while (pending_answers.size() != 0) @(negedge i_clk);
        repeat (bwf_pkg::TableEntries + 4) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= p;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        policy = p;
    endtask

    task automatic test_directed();
        send_item(bwf_pkg::MODE_ALLOC, 16'h0, 16'h0);
        send_item(bwf_pkg::MODE_FREE, 16'h0100, 16'h0010);
        send_item(bwf_pkg::MODE_FREE, 16'h0110, 16'h0020);
        send_item(bwf_pkg::MODE_FREE, 16'h00F0, 16'h0010);
        send_item(bwf_pkg::MODE_LOAD, 16'hFFF0, 16'hFFFF);
        send_item(bwf_pkg::MODE_FREE, 16'hFFE0, 16'hFFFF);
        send_item(bwf_pkg::MODE_LOAD, 16'h1000, 16'h0008);
        send_item(bwf_pkg::MODE_LOAD, 16'h2000, 16'h0020);
        send_item(bwf_pkg::MODE_ALLOC, 16'h0, 16'h0005);
        send_item(bwf_pkg::MODE_ALLOC, 16'hFFFF, 16'h0008);
        send_item(bwf_pkg::MODE_ALLOC, 16'h0, 16'h0000);
        send_item(bwf_pkg::MODE_ALLOC, 16'h0, 16'hFFFF);
        send_item(bwf_pkg::MODE_ALLOC, 16'h0, 16'hFFFD);
        send_item(MODE_UNUSED, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < bwf_pkg::TableEntries; i++)
            send_item(bwf_pkg::MODE_LOAD, 16'h4000 + 16'(i * 64), 16'h0004);
        send_item(bwf_pkg::MODE_FREE, 16'h9000, 16'h0004);
    endtask

    task automatic test_random(int items);
        logic [1:0] m;
        bwf_pkg::t_addr s, n;
        int k;
        for (int i = 0; i < items; i++) begin
            if (i % 60 == 0) burst = ($urandom_range(0, 2) == 0);
            k = $urandom_range(0, 99);
            m = (k < 15) ? bwf_pkg::MODE_LOAD : (k < 55) ? bwf_pkg::MODE_ALLOC
                : (k < 97) ? bwf_pkg::MODE_FREE : MODE_UNUSED;
            s = 16'($urandom_range(0, 255) * 16);
            n = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 96));
            if (m == bwf_pkg::MODE_FREE && tbl_count > 0 && $urandom_range(0, 1)) begin
                k = $urandom_range(0, tbl_count - 1);
                s = $urandom_range(0, 1) ? tbl_start[k] + tbl_len[k] : tbl_start[k] - n;
            end
            if ($urandom_range(0, 19) == 0) s = 16'($urandom);
            send_item(m, s, n);
        end
        burst = 0;
    endtask

    task automatic test_policies();
        for (int p = 0; p < 4; p++) begin
            drain_and_set_policy(p[0] ^ 1'b1);
            test_random(400);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        drain_and_set_policy(1'b0);
        test_directed();
        drain_and_set_policy(1'b1);
        test_directed();
        test_policies();
        i_valid <= 1'b0;
        while (pending_answers.size() != 0) @(negedge i_clk);
        repeat (bwf_pkg::TableEntries + 4) @(negedge i_clk);
        if (error_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
